// ===== rtl/b64d_pkg.sv =====
// Base64 decoder package: shared types for the front, queue and back stages.
// No dependencies.
package b64d_pkg;

  // one decoded unit of work: up to three bytes, then optionally a frame status item
  typedef struct packed {
    logic [2:0][7:0] bytes;   // bytes[0] goes out first
    logic [1:0]      cnt;     // number of valid bytes
    logic            done;    // frame close item follows the bytes
    logic            status;  // 1 = malformed frame
  } b64d_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64d_qstat_t;

endpackage

// ===== rtl/b64d_front.sv =====
// Base64 decoder front stage: character classification, group state, job build.
// Depends on b64d_pkg.
module b64d_front
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] char_byte
  input  logic        in_tlast,    // frame_last
  input  b64d_qstat_t q_stat,
  output logic        push,
  output b64d_job_t   job
);

  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [5:0] SEXTET_62  = 6'd62;
  localparam logic [5:0] SEXTET_63  = 6'd63;
  localparam logic [7:0] LOWER_BASE = 8'd26;
  localparam logic [7:0] DIGIT_BASE = 8'd52;

  typedef enum logic [2:0] {
    PAD_DATA = 3'b001,
    PAD_ONE  = 3'b010,
    PAD_END  = 3'b100
  } pad_state_t;

  logic        ignore_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [17:0] held_r, held_nxt;
  pad_state_t  pad_r, pad_nxt;
  logic        err_r, err_nxt;

  logic [7:0]  c;
  logic        is_sx;
  logic [5:0]  sx;
  logic        is_blank;
  logic        is_pad;
  logic        accept;
  logic        bad;

  assign c        = in_tdata;
  assign is_pad   = (c == CHAR_PAD);
  assign is_blank = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  assign in_tready = !q_stat.full;
  assign accept   = in_tvalid && in_tready;

  always_comb begin
    is_sx = 1'b1;
    sx    = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      sx = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      sx = 6'(c - 8'h61 + LOWER_BASE);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      sx = 6'(c - 8'h30 + DIGIT_BASE);
    end else if (c == 8'h2B || c == 8'h2D) begin
      sx = SEXTET_62;
    end else if (c == 8'h2F || c == 8'h5F) begin
      sx = SEXTET_63;
    end else begin
      is_sx = 1'b0;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    pad_nxt   = pad_r;
    err_nxt   = err_r;
    job       = '0;
    bad       = 1'b0;
    if (!err_r) begin
      case (pad_r)
        PAD_DATA: begin
          if (is_sx) begin
            if (phase_r == 2'd3) begin
              job.bytes[0] = held_r[17:10];
              job.bytes[1] = {held_r[9:2]};
              job.bytes[2] = {held_r[1:0], sx};
              job.cnt      = 2'd3;
              held_nxt     = '0;
              phase_nxt    = 2'd0;
            end else begin
              held_nxt  = {held_r[11:0], sx};
              phase_nxt = phase_r + 2'd1;
            end
          end else if (is_pad) begin
            if (phase_r == 2'd3) begin
              pad_nxt = PAD_END;
            end else if (phase_r == 2'd2) begin
              pad_nxt = PAD_ONE;
            end else begin
              err_nxt = 1'b1;
            end
          end else if (!is_blank && !ignore_r) begin
            err_nxt = 1'b1;
          end
        end
        PAD_ONE: begin
          if (is_pad) begin
            pad_nxt = PAD_END;
          end else if (!is_blank && !ignore_r) begin
            err_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (in_tlast) begin
      bad = err_nxt || (pad_nxt == PAD_ONE) || (phase_nxt == 2'd1);
      if (!bad) begin
        if (phase_nxt == 2'd2) begin
          job.bytes[0] = held_nxt[11:4];
          job.cnt      = 2'd1;
        end else if (phase_nxt == 2'd3) begin
          job.bytes[0] = held_nxt[17:10];
          job.bytes[1] = held_nxt[9:2];
          job.cnt      = 2'd2;
        end
      end
      job.done   = 1'b1;
      job.status = bad;
      phase_nxt  = '0;
      held_nxt   = '0;
      pad_nxt    = PAD_DATA;
      err_nxt    = 1'b0;
    end
  end

  assign push = accept && ((job.cnt != 2'd0) || job.done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ignore_r <= 1'b0;
      phase_r  <= '0;
      held_r   <= '0;
      pad_r    <= PAD_DATA;
      err_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ignore_r <= cfg_wr_data;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
        pad_r   <= pad_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

// ===== rtl/b64d_queue.sv =====
// Base64 decoder job queue between front and back stages.
// Depends on b64d_pkg.
module b64d_queue
  import b64d_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  b64d_job_t   wr_job,
  input  logic        pop,
  output b64d_job_t   rd_job,
  output b64d_qstat_t q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64d_job_t       mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign rd_job       = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/b64d_back.sv =====
// Base64 decoder back stage: expands jobs into result items, one per cycle unless the output stalls.
// Depends on b64d_pkg.
module b64d_back
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  b64d_qstat_t q_stat,
  input  b64d_job_t   head,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] data_byte
  output logic [2:0]  out_tuser,   // [0] has_byte, [1] frame_done, [2] status
  output logic        out_tlast    // run_last
);

  logic       busy_r;
  b64d_job_t  job_r;
  logic [1:0] idx_r;
  logic       out_tvalid_r;
  logic [7:0] out_tdata_r;
  logic [2:0] out_tuser_r;
  logic       out_tlast_r;

  logic [2:0] total;
  logic       has;
  logic       item_last;
  logic       load_out;

  assign total     = {1'b0, job_r.cnt} + {2'b0, job_r.done};
  assign has       = (idx_r < job_r.cnt);
  assign item_last = (({1'b0, idx_r} + 3'd1) == total);
  assign load_out  = busy_r && (!out_tvalid_r || out_tready);
  assign pop       = !q_stat.empty && (!busy_r || (load_out && item_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      idx_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (!out_tvalid_r || out_tready) begin
        out_tvalid_r <= busy_r;
      end
      if (pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (load_out) begin
        if (item_last) begin
          busy_r <= 1'b0;
          idx_r  <= '0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head;
    end
    if (load_out) begin
      out_tdata_r <= has ? job_r.bytes[idx_r] : 8'h00;
      out_tuser_r <= {job_r.status && !has, !has, has};
      out_tlast_r <= item_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

// ===== rtl/base64_decoder_validating.sv =====
// Validating Base64 decoder, top level: front stage, job queue, back stage.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
//
// Input stream: one ASCII character per transfer in in_tdata, in_tlast on the
// frame's final character. Standard and URL alphabets are both accepted;
// whitespace is skipped, '=' padding closes the data section.
// Output stream: one result per transfer. out_tdata is a decoded byte when
// out_tuser[0] is set; the frame's final result is a status item with
// out_tuser[1] set and out_tuser[2] = 1 for malformed input. out_tlast marks
// the last result caused by one input character.
// cfg_wr_en/cfg_wr_data write ignore_garbage; write only while idle.
// A character's job passes the job queue and the back stage's job register
// before its first result is registered. Input takes one character per cycle
// while the job queue (QUEUE_DEPTH entries) has room; output gives one result
// per cycle while the receiver is ready, 3 results for a group (3 bytes).
// Reset clears all frame state and ignore_garbage; no result is pending after.
// When the receiver stalls, results hold in the output register, the queue
// fills and in_tready drops.
module base64_decoder_validating
  import b64d_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] char_byte
  input  logic       in_tlast,    // frame_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] data_byte
  output logic [2:0] out_tuser,   // [0] has_byte, [1] frame_done, [2] status
  output logic       out_tlast    // run_last
);

  b64d_qstat_t q_stat;
  b64d_job_t   wr_job, rd_job;
  logic        push, pop;

  b64d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .q_stat      (q_stat),
    .push        (push),
    .job         (wr_job)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .q_stat (q_stat)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head       (rd_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("job popped from empty queue");

  a_status_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tuser[1] && out_tlast && out_tdata == 8'h00))
    else $error("status item without frame close, run end or zero data");

  a_byte_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (!out_tuser[1] && !out_tuser[2]))
    else $error("byte item carries frame status");
`endif

endmodule

// ===== test/tb_base64_decoder_validating.sv =====
`timescale 1ns / 1ps
// Testbench for base64_decoder_validating: directed and random Base64 frames,
// checked against a cycle-free decoder model kept in this file.
// Depends only on the RTL top level base64_decoder_validating.
module tb_base64_decoder_validating;

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int LIMIT_CYCLES  = 200000;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [6:0] NOT_B64  = 7'd64;

  localparam logic [1:0] PAD_NONE = 2'd0;  // still in data
  localparam logic [1:0] PAD_HALF = 2'd1;  // one '=' after two sextets
  localparam logic [1:0] PAD_END  = 2'd2;  // data section closed

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       rlast;
    logic       done;
    logic       st;
  } dec_result_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic       cfg_wr_data;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;

  // decoder model state
  logic        skip_garbage = 1'b0;
  logic [1:0]  grp_phase = 2'd0;
  logic [17:0] grp_bits = 18'd0;
  logic [1:0]  pad_st = PAD_NONE;
  logic        frame_bad = 1'b0;

  dec_result_t decoded_q[$];
  dec_result_t want;

  int  errors = 0;
  int  chars_sent = 0;
  int  cycle_cnt = 0;
  int  src_idle = 0;
  int  snk_stall = 0;
  int  hold_left = 0;
  int  hold_reqs = 0;
  int  hold_seen = 0;

  base64_decoder_validating DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  function automatic logic [6:0] b64_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 7'(c - "A");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
    if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
    if (c == "+" || c == "-") return 7'd62;
    if (c == "/" || c == "_") return 7'd63;
    return NOT_B64;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v, input bit url);
    if (v < 26) return "A" + v;
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return url ? "-" : "+";
    return url ? "_" : "/";
  endfunction

  function automatic logic [7:0] blank_char();
    logic [7:0] v;
    v = 8'($urandom_range(13, 8));
    return (v == 8'd8) ? " " : v;
  endfunction

  // predicts the results of one accepted character
  task automatic decode_char(input logic [7:0] c, input logic last);
    dec_result_t res[$];
    dec_result_t r;
    logic [6:0]  s;
    logic [23:0] grp;
    logic        bad;
    s = b64_value(c);
    r = '0;
    r.has = 1'b1;
    if (!frame_bad) begin
      if (pad_st == PAD_NONE) begin
        if (s != NOT_B64) begin
          if (grp_phase == 2'd3) begin
            grp = {grp_bits, s[5:0]};
            r.data = grp[23:16]; res.push_back(r);
            r.data = grp[15:8];  res.push_back(r);
            r.data = grp[7:0];   res.push_back(r);
            grp_bits = '0;
            grp_phase = 2'd0;
          end else begin
            grp_bits = {grp_bits[11:0], s[5:0]};
            grp_phase = grp_phase + 2'd1;
          end
        end else if (c == PAD_CHAR) begin
          if (grp_phase == 2'd3) pad_st = PAD_END;
          else if (grp_phase == 2'd2) pad_st = PAD_HALF;
          else frame_bad = 1'b1;
        end else if (!is_blank(c) && !skip_garbage) begin
          frame_bad = 1'b1;
        end
      end else if (pad_st == PAD_HALF) begin
        if (c == PAD_CHAR) pad_st = PAD_END;
        else if (!is_blank(c) && !skip_garbage) frame_bad = 1'b1;
      end
    end
    if (last) begin
      bad = frame_bad || pad_st == PAD_HALF || grp_phase == 2'd1;
      if (!bad) begin
        if (grp_phase == 2'd2) begin
          r.data = grp_bits[11:4]; res.push_back(r);
        end else if (grp_phase == 2'd3) begin
          r.data = grp_bits[17:10]; res.push_back(r);
          r.data = grp_bits[9:2];   res.push_back(r);
        end
      end
      r = '0;
      r.done = 1'b1;
      r.st = bad;
      res.push_back(r);
      grp_phase = 2'd0;
      grp_bits = '0;
      pad_st = PAD_NONE;
      frame_bad = 1'b0;
    end
    if (res.size() > 0) res[res.size()-1].rlast = 1'b1;
    foreach (res[i]) decoded_q.push_back(res[i]);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual data %0h user %b last %b",
                 $time, out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        check_field("data_byte", want.data, out_tdata);
        check_field("has_byte", 8'(want.has), 8'(out_tuser[0]));
        check_field("frame_done", 8'(want.done), 8'(out_tuser[1]));
        check_field("status", 8'(want.st), 8'(out_tuser[2]));
        check_field("run_last", 8'(want.rlast), 8'(out_tlast));
      end
    end
    if (rst_n && in_tvalid && in_tready) decode_char(in_tdata, in_tlast);
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_left = HOLD_CYCLES;
      hold_seen = hold_reqs;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= snk_stall);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input bit last);
    while ($urandom_range(99) < src_idle) @(negedge clk) in_tvalid <= 1'b0;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
  endtask

  task automatic send_frame(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk) in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_ignore_garbage(input logic v);
    wait_drained();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk) cfg_wr_en <= 1'b0;
    skip_garbage = v;
  endtask

  task automatic send_random_frame();
    logic [7:0]  fr[$];
    logic [7:0]  b[$];
    logic [23:0] w;
    int kind, nb, ns, i, j, k, pos;
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(6, 1)) fr.push_back(8'($urandom_range(255)));
    end else begin
      nb = $urandom_range(8);
      for (i = 0; i < nb + 2; i++) b.push_back(8'($urandom_range(255)));
      for (i = 0; i < nb; i += 3) begin
        k = nb - i;
        w = {b[i], b[i+1], b[i+2]};
        ns = (k >= 3) ? 4 : k + 1;
        for (j = 0; j < ns; j++) begin
          if ($urandom_range(9) == 0) fr.push_back(blank_char());
          fr.push_back(b64_char(w[23 - 6*j -: 6], 1'($urandom_range(1))));
        end
        if (k < 3 && $urandom_range(9) < 8) begin
          fr.push_back(PAD_CHAR);
          if (k == 1) begin
            if ($urandom_range(3) == 0) fr.push_back(blank_char());
            fr.push_back(PAD_CHAR);
          end
        end
      end
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(2, 1)) fr.push_back(8'($urandom_range(255)));
      if (kind < 30 && fr.size() > 0) begin
        pos = $urandom_range(fr.size() - 1);
        if ($urandom_range(1)) fr[pos] = PAD_CHAR;
        else fr[pos] = 8'($urandom_range(255));
      end
      if (fr.size() == 0) fr.push_back(blank_char());
    end
    for (i = 0; i < fr.size(); i++) send_char(fr[i], i == fr.size() - 1);
  endtask

  task automatic test_alphabet_and_padding();
    set_ignore_garbage(1'b0);
    send_frame("+/-_");
    send_frame("Az9=");
    send_frame("QQ= \t=");
    send_frame("Q=");
    send_frame("QQ=");
    send_frame("Q");
    send_frame("QR==");
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_garbage_skip();
    set_ignore_garbage(1'b1);
    send_frame("QQ=*=");
    send_char("T", 1'b0);
    send_char(8'hC3, 1'b0);
    send_frame("WE");
    send_frame("Q=");
  endtask

  task automatic test_random_frames(input int src_pct, input int snk_pct, input logic ign,
                                    input int n_chars);
    int start;
    set_ignore_garbage(ign);
    src_idle = src_pct;
    snk_stall = snk_pct;
    start = chars_sent;
    while (chars_sent - start < n_chars) send_random_frame();
  endtask

  task automatic test_backpressure();
    wait_drained();
    src_idle = 0;
    snk_stall = 0;
    hold_reqs++;
    send_frame("TWFueSBoYW5kcyBtYWtl");
    repeat (3) send_random_frame();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_alphabet_and_padding();
    test_garbage_skip();
    test_random_frames(0, 0, 1'b0, 55);
    test_random_frames(80, 0, 1'b1, 55);
    test_random_frames(0, 80, 1'b0, 55);
    test_random_frames(7, 7, 1'b1, 55);
    test_random_frames(0, 0, 1'b0, 55);
    test_backpressure();

    wait_drained();
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_decoder_validating.sv
test/tb_base64_decoder_validating.sv
